### rtl/eotp_pkg.sv
`default_nettype none

package eotp_pkg;

    localparam logic [15:0] KEPT_CODE_RESET = 16'd3;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TRUNC   = 2'd2,
        KIND_OVERRUN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        HDR_CODE_HI = 2'd0,
        HDR_CODE_LO = 2'd1,
        HDR_LEN_HI  = 2'd2,
        HDR_LEN_LO  = 2'd3
    } hdr_pos_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tlv_code;
        logic [7:0]  out_byte;
        logic [15:0] byte_offset;
        logic        option_last;
        logic        record_done;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       record_last;
    } item_t;

endpackage

`default_nettype wire

### rtl/eotp_in_reg.sv
`default_nettype none

module eotp_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     data_byte,
    input  wire logic           record_last,
    input  wire logic           advance,
    output eotp_pkg::item_t     item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload only loads on a transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= record_last;
        end
    end

    assign item.valid       = valid_reg;
    assign item.data_byte   = byte_reg;
    assign item.record_last = last_reg;

endmodule

`default_nettype wire

### rtl/eotp_parse.sv
`default_nettype none

module eotp_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire eotp_pkg::item_t item,
    input  wire logic           advance,
    input  wire logic [15:0]    kept_code,
    output eotp_pkg::result_t   result,
    output logic                result_valid
);

    logic [1:0]  hdr_count_reg;
    logic [1:0]  hdr_count_next;
    logic [15:0] code_reg;
    logic [15:0] code_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [15:0] index_reg;
    logic [15:0] index_next;
    logic        in_data_reg;
    logic        in_data_next;

    logic        complete;
    logic        kept;
    logic        opt_end;
    logic [15:0] index_inc;

    always_comb
    begin
        hdr_count_next = hdr_count_reg;
        code_next      = code_reg;
        len_next       = len_reg;
        index_next     = index_reg;
        in_data_next   = in_data_reg;
        result         = '0;
        result_valid   = 1'b0;
        complete       = 1'b0;
        kept           = (code_reg == kept_code);
        index_inc      = index_reg + 16'd1;
        opt_end        = (index_inc == len_reg);

        if (!in_data_reg)
        begin
            case (eotp_pkg::hdr_pos_t'(hdr_count_reg))
                eotp_pkg::HDR_CODE_HI: code_next = {item.data_byte, 8'h00};
                eotp_pkg::HDR_CODE_LO: code_next = code_reg | {8'h00, item.data_byte};
                eotp_pkg::HDR_LEN_HI:  len_next  = {item.data_byte, 8'h00};
                default:
                begin
                    len_next = len_reg | {8'h00, item.data_byte};
                    complete = 1'b1;
                end
            endcase
            if (complete)
            begin
                hdr_count_next = 2'd0;
                if (len_next != 16'd0)
                begin
                    in_data_next = 1'b1;
                    index_next   = 16'd0;
                end
            end
            else
            begin
                hdr_count_next = hdr_count_reg + 2'd1;
            end
            if (item.record_last)
            begin
                result_valid = 1'b1;
                if (!complete)
                begin
                    result.kind = eotp_pkg::KIND_TRUNC;
                end
                else if (in_data_next)
                begin
                    result.kind     = eotp_pkg::KIND_OVERRUN;
                    result.tlv_code = code_next;
                end
                else
                begin
                    result.kind        = eotp_pkg::KIND_OK;
                    result.record_done = 1'b1;
                end
            end
        end
        else
        begin
            index_next = index_inc;
            if (opt_end)
            begin
                in_data_next = 1'b0;
                index_next   = 16'd0;
            end
            if (item.record_last)
            begin
                result_valid = 1'b1;
                if (!opt_end)
                begin
                    result.kind     = eotp_pkg::KIND_OVERRUN;
                    result.tlv_code = code_reg;
                end
                else if (kept)
                begin
                    result.kind        = eotp_pkg::KIND_DATA;
                    result.tlv_code    = code_reg;
                    result.out_byte    = item.data_byte;
                    result.byte_offset = index_reg;
                    result.option_last = 1'b1;
                    result.record_done = 1'b1;
                end
                else
                begin
                    result.kind        = eotp_pkg::KIND_OK;
                    result.record_done = 1'b1;
                end
            end
            else if (kept)
            begin
                result_valid       = 1'b1;
                result.kind        = eotp_pkg::KIND_DATA;
                result.tlv_code    = code_reg;
                result.out_byte    = item.data_byte;
                result.byte_offset = index_reg;
                result.option_last = opt_end;
            end
        end

        // record end returns the walker to its starting point
        if (item.record_last)
        begin
            hdr_count_next = 2'd0;
            code_next      = 16'd0;
            len_next       = 16'd0;
            index_next     = 16'd0;
            in_data_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg <= 2'd0;
            code_reg      <= 16'd0;
            len_reg       <= 16'd0;
            index_reg     <= 16'd0;
            in_data_reg   <= 1'b0;
        end
        else if (advance)
        begin
            hdr_count_reg <= hdr_count_next;
            code_reg      <= code_next;
            len_reg       <= len_next;
            index_reg     <= index_next;
            in_data_reg   <= in_data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/eotp_out_reg.sv
`default_nettype none

module eotp_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire eotp_pkg::result_t result,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output eotp_pkg::result_t      out_result
);

    logic              valid_reg;
    logic              valid_next;
    eotp_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

### rtl/edns_option_tlv_parser.sv
// out_valid rises when the causing byte advances from the input register and its result loads into the output register
// throughput: one byte per cycle, limited only by the output handshake
// input register, one parse stage on the header and data counters, output register
// rst_n clears the counters, the valid flags and sets the kept code to 3
// the kept code register is held across records
`default_nettype none

module edns_option_tlv_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_code,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        record_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      tlv_code,
    output logic [7:0]       out_byte,
    output logic [15:0]      byte_offset,
    output logic             option_last,
    output logic             record_done
);

    logic [15:0]       kept_reg;
    eotp_pkg::item_t   item;
    eotp_pkg::result_t result;
    eotp_pkg::result_t out_result;
    logic              result_valid;
    logic              out_free;
    logic              advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= eotp_pkg::KEPT_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            kept_reg <= cfg_code;
        end
    end

    assign advance = item.valid && out_free;

    eotp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .record_last (record_last),
        .advance     (advance),
        .item        (item)
    );

    eotp_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .advance      (advance),
        .kept_code    (kept_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    eotp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && result_valid),
        .result     (result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign kind        = out_result.kind;
    assign tlv_code    = out_result.tlv_code;
    assign out_byte    = out_result.out_byte;
    assign byte_offset = out_result.byte_offset;
    assign option_last = out_result.option_last;
    assign record_done = out_result.record_done;

endmodule

`default_nettype wire

### dv/edns_option_tlv_parser_tb.sv
`default_nettype none

module edns_option_tlv_parser_tb;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_code = eotp_pkg::KEPT_CODE_RESET;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        record_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] tlv_code;
    logic [7:0]  out_byte;
    logic [15:0] byte_offset;
    logic        option_last;
    logic        record_done;

    // parser state mirrored on the testbench side
    logic [2:0]  hdr_count = '0;
    logic [15:0] opt_code = '0;
    logic [15:0] opt_len = '0;
    logic [15:0] data_pos = '0;
    logic        in_opt_data = 1'b0;
    logic [15:0] kept_code = eotp_pkg::KEPT_CODE_RESET;
    eotp_pkg::result_t expected_q[$];

    int mismatches = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int items_offered = 0;
    int records_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic [15:0] kept_sel = eotp_pkg::KEPT_CODE_RESET;
    logic [7:0]  rec_bytes[$];

    edns_option_tlv_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_code    (cfg_code),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .record_last (record_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .tlv_code    (tlv_code),
        .out_byte    (out_byte),
        .byte_offset (byte_offset),
        .option_last (option_last),
        .record_done (record_done)
    );

    always #5 clk = ~clk;

    function automatic void clear_record_state();
        hdr_count = '0;
        opt_code = '0;
        opt_len = '0;
        data_pos = '0;
        in_opt_data = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output eotp_pkg::result_t r);
        logic        hdr_done;
        logic [15:0] offset;
        logic        opt_end;
        logic        is_kept;
        r = '0;
        hdr_done = 1'b0;
        if (!in_opt_data)
        begin
            case (eotp_pkg::hdr_pos_t'(hdr_count[1:0]))
                eotp_pkg::HDR_CODE_HI: opt_code = {b, 8'h00};
                eotp_pkg::HDR_CODE_LO: opt_code = opt_code | {8'h00, b};
                eotp_pkg::HDR_LEN_HI:  opt_len = {b, 8'h00};
                default:
                begin
                    opt_len = opt_len | {8'h00, b};
                    hdr_done = 1'b1;
                end
            endcase
            if (hdr_done)
            begin
                hdr_count = '0;
                if (opt_len != 16'd0)
                begin
                    in_opt_data = 1'b1;
                    data_pos = '0;
                end
            end
            else
            begin
                hdr_count = hdr_count + 3'd1;
            end
            if (!last)
                return 1'b0;
            if (!hdr_done)
                r.kind = eotp_pkg::KIND_TRUNC;
            else if (in_opt_data)
            begin
                r.kind = eotp_pkg::KIND_OVERRUN;
                r.tlv_code = opt_code;
            end
            else
            begin
                r.kind = eotp_pkg::KIND_OK;
                r.record_done = 1'b1;
            end
            clear_record_state();
            return 1'b1;
        end

        offset = data_pos;
        is_kept = (opt_code == kept_code);
        opt_end = ((offset + 16'd1) == opt_len);
        data_pos = offset + 16'd1;
        if (opt_end)
        begin
            in_opt_data = 1'b0;
            data_pos = '0;
        end
        if (last)
        begin
            if (!opt_end)
            begin
                r.kind = eotp_pkg::KIND_OVERRUN;
                r.tlv_code = opt_code;
            end
            else if (is_kept)
            begin
                r.kind = eotp_pkg::KIND_DATA;
                r.tlv_code = opt_code;
                r.out_byte = b;
                r.byte_offset = offset;
                r.option_last = 1'b1;
                r.record_done = 1'b1;
            end
            else
            begin
                r.kind = eotp_pkg::KIND_OK;
                r.record_done = 1'b1;
            end
            clear_record_state();
            return 1'b1;
        end
        if (is_kept)
        begin
            r.kind = eotp_pkg::KIND_DATA;
            r.tlv_code = opt_code;
            r.out_byte = b;
            r.byte_offset = offset;
            r.option_last = opt_end;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t  %s: expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // prediction on input transfers, comparison on output transfers
    always @(posedge clk)
    begin
        eotp_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                kept_code = cfg_code;
                cfg_writes++;
            end
            if (in_valid && in_ready)
            begin
                if (parse_byte(data_byte, record_last, exp_r))
                    expected_q = {expected_q, exp_r};
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t  unexpected result: expected none, got kind %h code %h",
                             $time, kind, tlv_code);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("kind", 16'(exp_r.kind), 16'(kind));
                    check_field("tlv_code", exp_r.tlv_code, tlv_code);
                    check_field("out_byte", 16'(exp_r.out_byte), 16'(out_byte));
                    check_field("byte_offset", exp_r.byte_offset, byte_offset);
                    check_field("option_last", 16'(exp_r.option_last), 16'(option_last));
                    check_field("record_done", 16'(exp_r.record_done), 16'(record_done));
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        record_last <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_record();
        foreach (rec_bytes[i])
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
        items_offered += rec_bytes.size();
        records_sent++;
    endtask

    task automatic add_option(input logic [15:0] code, input logic [15:0] len);
        rec_bytes = {rec_bytes, code[15:8]};
        rec_bytes = {rec_bytes, code[7:0]};
        rec_bytes = {rec_bytes, len[15:8]};
        rec_bytes = {rec_bytes, len[7:0]};
        repeat (len)
            rec_bytes = {rec_bytes, 8'($urandom_range(255))};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_kept_code(input logic [15:0] code);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_code <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        kept_sel = code;
    endtask

    task automatic build_random_record();
        int pick;
        int len;
        int cut;
        logic [15:0] code;
        rec_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise
            repeat ($urandom_range(1, 10))
                rec_bytes = {rec_bytes, 8'($urandom_range(255))};
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                code = ($urandom_range(1) == 1) ? kept_sel : 16'($urandom_range(65535));
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = $urandom_range(9, 40);
                    default: len = $urandom_range(1, 8);
                endcase
                add_option(code, 16'(len));
            end
            if (pick < 30)
            begin
                // broken: record cut short
                cut = $urandom_range(0, rec_bytes.size() - 2);
                rec_bytes = rec_bytes[0:cut];
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        // kept option ends the record cleanly
        rec_bytes = '{8'h00, 8'h03, 8'h00, 8'h02, 8'h00, 8'hFF};
        send_record();
        // zero-length option ends the record
        rec_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
        send_record();
        // record ends inside a header
        rec_bytes = '{8'hFF, 8'h00};
        send_record();
        rec_bytes = '{8'hFF};
        send_record();
        // kept option overruns the record after two data bytes
        rec_bytes = '{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h11, 8'h22};
        send_record();
        // record ends right after a header with nonzero length
        rec_bytes = '{8'h00, 8'h08, 8'h00, 8'h01};
        send_record();
        // skipped option ends the record cleanly
        rec_bytes = '{8'h00, 8'h0A, 8'h00, 8'h01, 8'hA5};
        send_record();
        wait_drained();
    endtask

    task automatic test_kept_code_extremes();
        logic [15:0] codes[2];
        codes = '{16'h0000, 16'hFFFF};
        foreach (codes[i])
        begin
            write_kept_code(codes[i]);
            rec_bytes.delete();
            add_option(16'h0000, 16'd3);
            add_option(16'hFFFF, 16'd2);
            add_option(codes[i], 16'd0);
            add_option(16'h0003, 16'd1);
            send_record();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        write_kept_code(16'h5AA5);
        rec_bytes.delete();
        add_option(kept_sel, 16'd60);
        hold_reqs <= hold_reqs + 1;
        send_record();
        // sender pauses until every result is out
        wait_drained();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int n_items);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        write_kept_code(16'($urandom_range(65535)));
        start = items_offered;
        while (items_offered - start < n_items)
        begin
            build_random_record();
            send_record();
            if ($urandom_range(19) == 0)
                write_kept_code(16'($urandom_range(65535)));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 370);
        run_random_phase(77, 0, 370);
        run_random_phase(0, 77, 370);
        run_random_phase(19, 19, 370);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_kept_code_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        $display("covered %0d bytes in %0d records, %0d results checked, %0d code writes",
                 items_offered, records_sent, results_seen, cfg_writes);
        $display("idle phases: none, sender, receiver, both, plus a long receiver hold-off");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(10 * 2_000_000);
        $display("timeout waiting for the parser");
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/eotp_pkg.sv
rtl/eotp_in_reg.sv
rtl/eotp_parse.sv
rtl/eotp_out_reg.sv
rtl/edns_option_tlv_parser.sv
dv/edns_option_tlv_parser_tb.sv
